/* sv/hvs_pkg.sv */
`timescale 1ns / 1ps
// hvs_pkg: shared field widths, request action codes and weight constants
// for the log-domain hmm viterbi scorer; no dependencies
package hvs_pkg;

    // request field widths
    localparam int ACTION_W       = 2;
    localparam int STATE_FIELD_W  = 3;
    localparam int SYMBOL_FIELD_W = 4;
    localparam int WEIGHT_W       = 16;

    // request action codes
    localparam logic [ACTION_W-1:0] ACT_LOAD_TRANS = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOAD_EMIT  = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_START      = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_SYMBOL     = 2'd3;

    // q7.8 log weight, most negative code means log of zero
    typedef logic signed [WEIGHT_W-1:0] weight_t;
    localparam weight_t W_IMPOSSIBLE = 16'sh8000;

endpackage

/* sv/hvs_in_if.sv */
`timescale 1ns / 1ps
// hvs_in_if: request channel of the hmm viterbi scorer (valid/ready + fields)
// depends on hvs_pkg
interface hvs_in_if
    import hvs_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic [STATE_FIELD_W-1:0]  from_state;
    logic [STATE_FIELD_W-1:0]  to_state;
    logic [SYMBOL_FIELD_W-1:0] symbol;
    weight_t                   weight;

    modport source (
        output valid, action, from_state, to_state, symbol, weight,
        input  ready
    );

    modport sink (
        input  valid, action, from_state, to_state, symbol, weight,
        output ready
    );
endinterface

/* sv/hvs_out_if.sv */
`timescale 1ns / 1ps
// hvs_out_if: result channel of the hmm viterbi scorer (valid/ready + score)
// no dependencies
interface hvs_out_if #(
    parameter int SCORE_BITS = 24
);
    logic                         valid;
    logic                         ready;
    logic signed [SCORE_BITS-1:0] best_score;
    logic                         path_alive;

    modport source (
        output valid, best_score, path_alive,
        input  ready
    );

    modport sink (
        input  valid, best_score, path_alive,
        output ready
    );
endinterface

/* sv/hmm_viterbi_log_scorer.sv */
`timescale 1ns / 1ps
// hmm_viterbi_log_scorer: log-domain viterbi step of a discrete hmm with one
// shared saturating adder; depends on hvs_pkg, hvs_in_if, hvs_out_if
//
//  channel  modport  moves                                          per request
//  cmd      sink     action, from_state, to_state, symbol, weight   one command
//  res      source   best_score, path_alive                         symbol only
//
// loads and start complete when accepted and leave the scorer idle. for a
// symbol, each destination state scans all predecessors through the
// transition memory port and one saturating adder, then reuses that adder
// for the emission weight. cmd.ready is high only when idle.
// the result sits in an output register; a held result stalls only the end
// of the next symbol. reset clears path scores (state 0 zero, others floor);
// the weight memories hold garbage until loaded.
module hmm_viterbi_log_scorer
    import hvs_pkg::*;
#(
    parameter int STATES     = 8,
    parameter int SYMBOLS    = 16,
    parameter int SCORE_BITS = 24
) (
    input  logic      clk,
    input  logic      rst_n,
    hvs_in_if.sink    cmd,
    hvs_out_if.source res
);

    localparam int SW     = $clog2(STATES);
    localparam int TDEPTH = STATES * STATES;
    localparam int TAW    = $clog2(TDEPTH);
    localparam int EDEPTH = STATES * SYMBOLS;
    localparam int EAW    = $clog2(EDEPTH);
    localparam int SB     = SCORE_BITS;

    localparam logic signed [SB-1:0] SCORE_FLOOR = {1'b1, {(SB-1){1'b0}}};
    localparam logic signed [SB-1:0] SCORE_TOP   = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] SCORE_ZERO  = '0;
    localparam logic [SW-1:0]        LAST_STATE  = SW'(STATES - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SCAN    = 3'd1;
    localparam logic [2:0] ST_DRAIN_A = 3'd2;
    localparam logic [2:0] ST_DRAIN_B = 3'd3;
    localparam logic [2:0] ST_EMIT    = 3'd4;
    localparam logic [2:0] ST_FLUSH   = 3'd5;
    localparam logic [2:0] ST_OUT     = 3'd6;

    // saturating score + weight; floor or impossible weight stays floor
    function automatic logic signed [SB-1:0] sat_add(
        input logic signed [SB-1:0] score,
        input weight_t              w
    );
        logic signed [SB:0] s;
        logic signed [SB-1:0] r;
        s = (SB+1)'(score) + (SB+1)'(w);
        if (score == SCORE_FLOOR || w == W_IMPOSSIBLE)
            r = SCORE_FLOOR;
        else if (s <= (SB+1)'(SCORE_FLOOR))
            r = SCORE_FLOOR;
        else if (s > (SB+1)'(SCORE_TOP))
            r = SCORE_TOP;
        else
            r = SB'(s);
        return r;
    endfunction

    // weight memories
    weight_t trans_mem [TDEPTH];
    weight_t emis_mem  [EDEPTH];
    weight_t trans_rd_reg;
    weight_t emis_rd_reg;

    // score storage
    logic signed [SB-1:0] path_reg [STATES];
    logic signed [SB-1:0] next_reg [STATES];

    // control
    logic [2:0]                state_reg, state_next;
    logic [SW-1:0]             src_reg, src_next;
    logic [SW-1:0]             dst_reg, dst_next;
    logic [SYMBOL_FIELD_W-1:0] sym_reg;
    logic                      sym_ok_reg;
    logic                      v1_reg, v2_reg, st_v_reg;
    logic [SW-1:0]             src1_reg;
    logic [SW-1:0]             dst_st_reg;

    // datapath
    logic signed [SB-1:0] sum_reg;
    logic signed [SB-1:0] max_reg;
    logic signed [SB-1:0] best_reg;
    logic signed [SB-1:0] out_best_reg;
    logic                 out_valid_reg, out_valid_next;

    logic                 cmd_fire;
    logic                 out_load;
    logic [TAW-1:0]       trans_rd_addr, trans_wr_addr;
    logic [EAW-1:0]       emis_rd_addr, emis_wr_addr;
    logic                 from_ok, to_ok, load_sym_ok;
    logic                 trans_we, emis_we;
    weight_t              add_w;
    logic signed [SB-1:0] add_score;
    logic signed [SB-1:0] add_result;
    weight_t              emis_w;

    assign cmd.ready = (state_reg == ST_IDLE);
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign out_load  = (state_reg == ST_OUT) && (!out_valid_reg || res.ready);

    // load address decode and range checks
    assign from_ok       = int'(cmd.from_state) < STATES;
    assign to_ok         = int'(cmd.to_state) < STATES;
    assign load_sym_ok   = int'(cmd.symbol) < SYMBOLS;
    assign trans_wr_addr = TAW'(int'(cmd.from_state) * STATES + int'(cmd.to_state));
    assign emis_wr_addr  = EAW'(int'(cmd.to_state) * SYMBOLS + int'(cmd.symbol));
    assign trans_we      = cmd_fire && (cmd.action == ACT_LOAD_TRANS) && from_ok && to_ok;
    assign emis_we       = cmd_fire && (cmd.action == ACT_LOAD_EMIT) && to_ok && load_sym_ok;

    // scan addresses
    assign trans_rd_addr = TAW'(int'(src_reg) * STATES + int'(dst_reg));
    assign emis_rd_addr  = EAW'(int'(dst_reg) * SYMBOLS + int'(sym_reg));

    // transition weight memory
    always_ff @(posedge clk)
    begin
        if (trans_we)
            trans_mem[trans_wr_addr] <= cmd.weight;
        trans_rd_reg <= trans_mem[trans_rd_addr];
    end

    // emission weight memory
    always_ff @(posedge clk)
    begin
        if (emis_we)
            emis_mem[emis_wr_addr] <= cmd.weight;
        emis_rd_reg <= emis_mem[emis_rd_addr];
    end

    // shared adder operand select: predecessor scan or emission step
    assign emis_w     = sym_ok_reg ? emis_rd_reg : W_IMPOSSIBLE;
    assign add_score  = (state_reg == ST_EMIT) ? max_reg : path_reg[src1_reg];
    assign add_w      = (state_reg == ST_EMIT) ? emis_w : trans_rd_reg;
    assign add_result = sat_add(add_score, add_w);

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        src_next   = src_reg;
        dst_next   = dst_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_fire && cmd.action == ACT_SYMBOL)
                begin
                    state_next = ST_SCAN;
                    src_next   = '0;
                    dst_next   = '0;
                end
            end
            ST_SCAN:
            begin
                if (src_reg == LAST_STATE)
                begin
                    src_next   = '0;
                    state_next = ST_DRAIN_A;
                end
                else
                begin
                    src_next = src_reg + 1'b1;
                end
            end
            ST_DRAIN_A:
            begin
                state_next = ST_DRAIN_B;
            end
            ST_DRAIN_B:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (dst_reg == LAST_STATE)
                begin
                    state_next = ST_FLUSH;
                end
                else
                begin
                    dst_next   = dst_reg + 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            src_reg   <= '0;
            dst_reg   <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            st_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            src_reg   <= src_next;
            dst_reg   <= dst_next;
            v1_reg    <= (state_reg == ST_SCAN);
            v2_reg    <= v1_reg;
            st_v_reg  <= (state_reg == ST_EMIT);
        end
    end

    // request latch and pipeline tags
    always_ff @(posedge clk)
    begin
        if (cmd_fire && cmd.action == ACT_SYMBOL)
        begin
            sym_reg    <= cmd.symbol;
            sym_ok_reg <= int'(cmd.symbol) < SYMBOLS;
        end
        src1_reg <= src_reg;
        if (state_reg == ST_EMIT)
            dst_st_reg <= dst_reg;
    end

    // adder result, running maximum over predecessors, best over states
    always_ff @(posedge clk)
    begin
        if (v1_reg || state_reg == ST_EMIT)
            sum_reg <= add_result;

        if (cmd_fire || state_reg == ST_EMIT)
            max_reg <= SCORE_FLOOR;
        else if (v2_reg && sum_reg > max_reg)
            max_reg <= sum_reg;

        if (cmd_fire)
            best_reg <= SCORE_FLOOR;
        else if (st_v_reg && sum_reg > best_reg)
            best_reg <= sum_reg;
    end

    // scratch scores for the step in progress
    always_ff @(posedge clk)
    begin
        if (st_v_reg)
            next_reg[dst_st_reg] <= sum_reg;
    end

    // path scores: start request resets, end of step commits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < STATES; i++)
                path_reg[i] <= (i == 0) ? SCORE_ZERO : SCORE_FLOOR;
        end
        else if (cmd_fire && cmd.action == ACT_START)
        begin
            for (int i = 0; i < STATES; i++)
                path_reg[i] <= (i == 0) ? SCORE_ZERO : SCORE_FLOOR;
        end
        else if (out_load)
        begin
            for (int i = 0; i < STATES; i++)
                path_reg[i] <= next_reg[i];
        end
    end

    // output register
    assign out_valid_next = out_load || (out_valid_reg && !res.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_best_reg <= best_reg;
    end

    assign res.valid      = out_valid_reg;
    assign res.best_score = out_best_reg;
    assign res.path_alive = (out_best_reg != SCORE_FLOOR);

endmodule
